/* src/css_pkg.sv */
// css_pkg: shared types and constants for the charging station selector.
// Used by charging_station_select and css_checker. No dependencies.
package css_pkg;

    localparam int DIST_W = 32;   // unsigned 24.8 distance
    localparam int SUM_W  = 33;   // from-leg plus to-leg, never overflows
    localparam int NODE_W = 7;    // node fields of a transaction
    localparam int STN_W  = 8;    // station result field

    // transaction opcodes; code 3 is unused and ignored
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_NEAREST  = 2'd1;
    localparam logic [1:0] OP_FEASIBLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CUSTOMER_COUNT = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT     = 2'd1;
    localparam logic [1:0] CFG_MAX_REACH      = 2'd2;

    // station code when nothing qualifies (-1)
    localparam logic [STN_W-1:0] STATION_NONE = 8'hFF;

endpackage

/* src/charging_station_select.sv */
// charging_station_select: top level; distance table in one synchronous RAM,
// scanned station by station for the cheapest detour. Depends on css_pkg.
//
// channel   direction  handshake                      payload
// --------  ---------  -----------------------------  ----------------------------------------
// command   in         start & !busy                  i_opcode, i_load_*, i_from_node,
//                                                     i_to_node, i_first_leg_limit
// result    out        o_strobe, one cycle, no stall  o_station, o_found
// config    in         i_cfg_we, no wait              i_cfg_index, i_cfg_data
//
// A load transaction is a RAM write and leaves the block idle. A query holds
// busy while it scans: each station reads two table entries (nearest) or three
// (feasible) through the single RAM read port, the two endpoints are skipped,
// and the scan ends by emptying the read and compare stages. The result
// strobes in the first cycle in which busy is low.
// Reset sets control and config state only; the table holds garbage until
// loaded, and no clearing pass runs. Results cannot be stalled: o_strobe marks
// exactly one cycle, and busy is already low in that cycle.
module charging_station_select
    import css_pkg::*;
#(
    parameter int MAX_NODES = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic [NODE_W-1:0]        i_load_row,
    input  logic [NODE_W-1:0]        i_load_col,
    input  logic [DIST_W-1:0]        i_load_distance,
    input  logic [NODE_W-1:0]        i_from_node,
    input  logic [NODE_W-1:0]        i_to_node,
    input  logic [DIST_W-1:0]        i_first_leg_limit,
    output logic                     o_strobe,
    output logic signed [STN_W-1:0]  o_station,
    output logic                     o_found,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [DIST_W-1:0]        i_cfg_data
);

    localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;  // node index bits
    localparam int CW    = $clog2(MAX_NODES + 1);                    // holds MAX_NODES itself
    localparam int EW    = (CW > 8) ? CW : 8;                        // scan counter width
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} t_state;
    typedef enum logic [1:0] {PH_FROM, PH_TO, PH_BACK} t_phase;

    // config registers
    logic [6:0]        r_customer_count;
    logic [7:0]        r_node_count;
    logic [DIST_W-1:0] r_max_reach;

    // sequencer
    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [EW-1:0]     r_s, n_s;
    logic [EW-1:0]     r_end;

    // query held for the whole scan
    logic [EW-1:0]     r_from, r_to;
    logic              r_from_oob, r_to_oob;
    logic              r_feasible;
    logic [DIST_W-1:0] r_limit;

    // RAM and its read tag (registered read)
    logic [DIST_W-1:0] mem [DEPTH];
    logic [DIST_W-1:0] r_rd_data;
    logic              r_t_valid, r_t_zero, r_t_last;
    t_phase            r_t_phase;
    logic [EW-1:0]     r_t_s;

    // per-station accumulation
    logic [DIST_W-1:0] r_first;
    logic              r_c_valid, r_c_ok;
    logic [SUM_W-1:0]  r_c_sum;
    logic [EW-1:0]     r_c_s;

    // running best
    logic              r_have;
    logic [SUM_W-1:0]  r_best_sum;
    logic [EW-1:0]     r_best;

    logic [EW-1:0]     w_row_e, w_col_e, w_from_e, w_to_e, w_max_e, w_cnt_e;
    logic              w_accept, w_query, w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic              w_scan_done, w_skip, w_issue, w_zero, w_last;
    logic [DIST_W-1:0] w_d;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && (r_state == ST_IDLE);
    assign w_query  = w_accept && ((i_opcode == OP_NEAREST) || (i_opcode == OP_FEASIBLE));

    assign w_row_e  = EW'(i_load_row);
    assign w_col_e  = EW'(i_load_col);
    assign w_from_e = EW'(i_from_node);
    assign w_to_e   = EW'(i_to_node);
    assign w_max_e  = EW'(MAX_NODES);
    assign w_cnt_e  = EW'(r_node_count);

    // loads outside the table are dropped
    assign w_we    = w_accept && (i_opcode == OP_LOAD) &&
                     (w_row_e < w_max_e) && (w_col_e < w_max_e);
    assign w_waddr = {w_row_e[NW-1:0], w_col_e[NW-1:0]};

    assign w_scan_done = (r_s >= r_end);
    assign w_skip      = (r_s == r_from) || (r_s == r_to);
    assign w_issue     = (r_state == ST_SCAN) && !w_scan_done && !w_skip;
    assign w_last      = r_feasible ? (r_phase == PH_BACK) : (r_phase == PH_TO);

    // read address per phase: [from][s], [to][s], then [s][to] for the reach check
    always_comb begin
        unique case (r_phase)
            PH_FROM: begin
                w_raddr = {r_from[NW-1:0], r_s[NW-1:0]};
                w_zero  = r_from_oob;
            end
            PH_TO: begin
                w_raddr = {r_to[NW-1:0], r_s[NW-1:0]};
                w_zero  = r_to_oob;
            end
            default: begin
                w_raddr = {r_s[NW-1:0], r_to[NW-1:0]};
                w_zero  = r_to_oob;
            end
        endcase
    end

    // endpoints beyond the table read as zero
    assign w_d = r_t_zero ? '0 : r_rd_data;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_s     = r_s;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_SCAN;
                    n_phase = PH_FROM;
                    n_s     = EW'(r_customer_count) + EW'(1);
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_DRAIN;
                end else if (w_skip) begin
                    n_s = r_s + EW'(1);
                end else if (w_last) begin
                    n_s     = r_s + EW'(1);
                    n_phase = PH_FROM;
                end else if (r_phase == PH_FROM) begin
                    n_phase = PH_TO;
                end else begin
                    n_phase = PH_BACK;
                end
            end
            ST_DRAIN: begin
                // wait until the read and compare stages are empty
                if (!r_t_valid && !r_c_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_load_distance;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_phase          <= PH_FROM;
            r_t_valid        <= 1'b0;
            r_c_valid        <= 1'b0;
            r_have           <= 1'b0;
            o_strobe         <= 1'b0;
            r_customer_count <= '0;
            r_node_count     <= 8'd128;
            r_max_reach      <= '1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUSTOMER_COUNT: r_customer_count <= i_cfg_data[6:0];
                    CFG_NODE_COUNT:     r_node_count     <= i_cfg_data[7:0];
                    CFG_MAX_REACH:      r_max_reach      <= i_cfg_data;
                    default:            ;
                endcase
            end

            r_state <= n_state;
            r_phase <= n_phase;
            r_s     <= n_s;

            // read tag
            r_t_valid <= w_issue;
            r_t_phase <= r_phase;
            r_t_zero  <= w_zero;
            r_t_last  <= w_last;
            r_t_s     <= r_s;

            // assemble legs of one station
            r_c_valid <= r_t_valid && r_t_last;
            if (r_t_valid) begin
                case (r_t_phase)
                    PH_FROM: r_first <= w_d;
                    PH_TO:   r_c_sum <= {1'b0, r_first} + {1'b0, w_d};
                    default: ;
                endcase
                if (r_t_last) begin
                    r_c_s  <= r_t_s;
                    r_c_ok <= !r_feasible ||
                              ((r_first < r_limit) && (w_d < r_max_reach));
                end
            end

            // keep the first strict minimum; a new query starts empty
            if (w_query) begin
                r_have <= 1'b0;
            end else if (r_c_valid && r_c_ok && (!r_have || (r_c_sum < r_best_sum))) begin
                r_have <= 1'b1;
            end
            if (r_c_valid && r_c_ok && (!r_have || (r_c_sum < r_best_sum))) begin
                r_best_sum <= r_c_sum;
                r_best     <= r_c_s;
            end

            if (w_query) begin
                r_feasible <= (i_opcode == OP_FEASIBLE);
                r_from     <= w_from_e;
                r_to       <= w_to_e;
                r_from_oob <= (w_from_e >= w_max_e);
                r_to_oob   <= (w_to_e >= w_max_e);
                r_limit    <= i_first_leg_limit;
                r_end      <= (w_cnt_e > w_max_e) ? w_max_e : w_cnt_e;
            end
            o_strobe <= (r_state == ST_DRAIN) && (n_state == ST_IDLE);
            if ((r_state == ST_DRAIN) && (n_state == ST_IDLE)) begin
                o_found   <= r_have;
                o_station <= r_have ? r_best[STN_W-1:0] : STATION_NONE;
            end
        end
    end

endmodule

/* src/css_checker.sv */
// css_checker: port-level checks on charging_station_select, attached by bind.
// Depends on css_pkg.
module css_checker
    import css_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_opcode,
    input logic             o_strobe,
    input logic [STN_W-1:0] o_station,
    input logic             o_found
);

    // a query keeps the block busy from the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && ((i_opcode == OP_NEAREST) || (i_opcode == OP_FEASIBLE))
        |=> busy)
        else $error("query accepted but block not busy");

    // a load finishes in its own cycle and produces nothing
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_LOAD) |=> !busy && !o_strobe)
        else $error("load transaction caused busy or a result");

    // a result appears only once the scan is over
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result while still busy");

    // one result per query
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result repeated");

    // no station means the -1 code
    a_none_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |-> (o_station == STATION_NONE))
        else $error("not found but station is not -1");

endmodule

bind charging_station_select css_checker u_css_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_opcode  (i_opcode),
    .o_strobe  (o_strobe),
    .o_station (o_station),
    .o_found   (o_found)
);
